// ----- hw/rtl/fjot_pkg.sv -----
// fjot_pkg: shared types, codes and character helpers for the flat JSON
// object tokenizer. No dependencies.
`default_nettype none

package fjot_pkg;

  // Parse phase of the tokenizer.
  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_KEY       = 4'd1,
    PH_KEY_STR   = 4'd2,
    PH_KEY_ESC   = 4'd3,
    PH_AFTER_KEY = 4'd4,
    PH_COLON     = 4'd5,
    PH_VAL_STR   = 4'd6,
    PH_VAL_ESC   = 4'd7,
    PH_BARE      = 4'd8,
    PH_AFTER_VAL = 4'd9,
    PH_DONE_OK   = 4'd10,
    PH_DONE_BAD  = 4'd11
  } ph_e;

  // Result word kinds.
  typedef enum logic [2:0] {
    KIND_KEY    = 3'd0,
    KIND_VAL    = 3'd1,
    KIND_PAIR   = 3'd2,
    KIND_ACCEPT = 3'd3,
    KIND_REJECT = 3'd4
  } kind_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_FL_RD   = 3'd1,
    ST_FL_EMIT = 3'd2,
    ST_MAIN    = 3'd3,
    ST_PAIR    = 3'd4,
    ST_END     = 3'd5
  } st_e;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Commands from controller to datapath.
  typedef struct packed {
    logic take;        // input ready
    logic flush_rd;    // read held whitespace entry
    logic flush_emit;  // send the entry just read
    logic main_step;   // main word and/or whitespace store
    logic pair_emit;   // closing pair end
    logic end_emit;    // text end mark
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic in_valid;
    logic plan_flush;  // decoded from the word at the input
    logic main_en;
    logic pair_en;
    logic end_en;
    logic flush_last;
    logic out_free;
  } sts_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_N:    r = CH_LF;
      CH_R:    r = CH_CR;
      CH_T:    r = CH_TAB;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fjot_in_if.sv -----
// fjot_in_if: input byte channel (valid/ready plus text byte and last flag).
// No dependencies.
`default_nettype none

interface fjot_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fjot_out_if.sv -----
// fjot_out_if: result channel (valid/ready plus kind, byte and flags).
// No dependencies.
`default_nettype none

interface fjot_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       ws_overflow;
  logic       run_last;

  modport source (output valid, output out_kind, output out_byte,
                  output ws_overflow, output run_last, input ready);
  modport sink   (input valid, input out_kind, input out_byte,
                  input ws_overflow, input run_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/flat_json_object_tokenizer_unit.sv -----
// flat_json_object_tokenizer_unit: top level of the flat JSON object tokenizer.
// Depends on fjot_pkg, fjot_in_if, fjot_out_if, fjot_ctrl and fjot_dp.
//
//   channel | dir | word fields                                  | handshake
//   --------+-----+----------------------------------------------+------------
//   in_i    | in  | in_byte[7:0], in_last                        | valid/ready
//   out_o   | out | out_kind[2:0], out_byte[7:0], ws_overflow,   | valid/ready
//           |     | run_last                                     |
//
// One input word at a time. A word is accepted, then its decode step loads
// at most one result; each held whitespace byte released by a flush is
// first read from the RAM, then sent, and a pair end or end mark on the
// final byte each take a step of their own.
// Reset clears the phase and the hold count; the hold RAM needs no clearing.
// A stalled result register holds the sequencer in place; the next input
// word is taken as soon as the last result of the current word is loaded.
`default_nettype none

module flat_json_object_tokenizer_unit #(
  parameter int unsigned WS_DEPTH = 16  // held whitespace bytes, 1..256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fjot_in_if.sink    in_i,
  fjot_out_if.source out_o
);
  import fjot_pkg::*;

  cmd_t cmd;  // controller -> datapath
  sts_t sts;  // datapath -> controller

  // Sequencer: walks flush, main word, pair end and end mark for each byte.
  fjot_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // Datapath: decode, phase, whitespace hold RAM, result register.
  fjot_dp #(
    .WS_DEPTH(WS_DEPTH)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o),
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/fjot_ram.sv -----
// fjot_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fjot_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fjot_ctrl.sv -----
// fjot_ctrl: sequencing state machine of the tokenizer.
// Depends on fjot_pkg.
`default_nettype none

module fjot_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fjot_pkg::sts_t sts_i,
  output fjot_pkg::cmd_t     cmd_o
);
  import fjot_pkg::*;

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = 1'b1;
        if (sts_i.in_valid) begin
          state_d = sts_i.plan_flush ? ST_FL_RD : ST_MAIN;
        end
      end
      ST_FL_RD: begin
        cmd_o.flush_rd = 1'b1;
        state_d        = ST_FL_EMIT;
      end
      ST_FL_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.flush_emit = 1'b1;
          state_d          = sts_i.flush_last ? ST_MAIN : ST_FL_RD;
        end
      end
      ST_MAIN: begin
        if (!sts_i.main_en || sts_i.out_free) begin
          cmd_o.main_step = 1'b1;
          if (sts_i.pair_en) begin
            state_d = ST_PAIR;
          end else if (sts_i.end_en) begin
            state_d = ST_END;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAIR: begin
        if (sts_i.out_free) begin
          cmd_o.pair_emit = 1'b1;
          state_d         = ST_END;
        end
      end
      ST_END: begin
        if (sts_i.out_free) begin
          cmd_o.end_emit = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fjot_dp.sv -----
// fjot_dp: byte decoder, parse phase, whitespace hold buffer and result
// register. Depends on fjot_pkg, fjot_in_if, fjot_out_if and fjot_ram.
`default_nettype none

module fjot_dp #(
  parameter int unsigned WS_DEPTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  fjot_in_if.sink             in_i,
  fjot_out_if.source          out_o,
  input  wire fjot_pkg::cmd_t cmd_i,
  output fjot_pkg::sts_t      sts_o
);
  import fjot_pkg::*;

  localparam int unsigned CW = $clog2(WS_DEPTH + 1);
  localparam int unsigned AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  // ---- decode of the word at the input ----
  logic [7:0] b;
  logic       last, ws, delim;
  ph_e        np;
  logic       m_en, f_en, f_ovf, s_en, clr;
  kind_e      m_kind;
  logic [7:0] m_byte;
  logic       pair_en;
  kind_e      end_kind;

  ph_e        phase_q;
  logic [CW-1:0] cnt_q;

  assign b     = in_i.in_byte;
  assign last  = in_i.in_last;
  assign ws    = is_ws(b);
  assign delim = (b == CH_COMMA) || (b == CH_RBRACE);

  always_comb begin
    np     = phase_q;
    m_en   = 1'b0;
    m_kind = KIND_VAL;
    m_byte = b;
    f_en   = 1'b0;
    f_ovf  = 1'b0;
    s_en   = 1'b0;
    clr    = 1'b0;
    case (phase_q)
      PH_START: begin
        if (!ws) np = (b == CH_LBRACE) ? PH_KEY : PH_DONE_BAD;
      end
      PH_KEY: begin
        if (!ws) np = (b == CH_QUOTE) ? PH_KEY_STR : PH_DONE_OK;
      end
      PH_KEY_STR, PH_VAL_STR: begin
        m_kind = (phase_q == PH_KEY_STR) ? KIND_KEY : KIND_VAL;
        if (b == CH_QUOTE) begin
          np = (phase_q == PH_KEY_STR) ? PH_AFTER_KEY : PH_AFTER_VAL;
        end else if (b == CH_BSLASH && !last) begin
          np = (phase_q == PH_KEY_STR) ? PH_KEY_ESC : PH_VAL_ESC;
        end else begin
          m_en = 1'b1;  // plain byte, or backslash as final byte
        end
      end
      PH_KEY_ESC, PH_VAL_ESC: begin
        m_kind = (phase_q == PH_KEY_ESC) ? KIND_KEY : KIND_VAL;
        m_en   = 1'b1;
        m_byte = unescape(b);
        np     = (phase_q == PH_KEY_ESC) ? PH_KEY_STR : PH_VAL_STR;
      end
      PH_AFTER_KEY: begin
        if (!ws) np = (b == CH_COLON) ? PH_COLON : PH_DONE_OK;
      end
      PH_COLON: begin
        if (!ws) begin
          if (b == CH_QUOTE) begin
            np = PH_VAL_STR;
          end else if (delim) begin
            m_en   = 1'b1;
            m_kind = KIND_PAIR;
            m_byte = '0;
            np     = (b == CH_COMMA) ? PH_KEY : PH_DONE_OK;
          end else begin
            clr  = 1'b1;
            m_en = 1'b1;
            np   = PH_BARE;
          end
        end
      end
      PH_BARE: begin
        if (delim) begin
          clr    = 1'b1;
          m_en   = 1'b1;
          m_kind = KIND_PAIR;
          m_byte = '0;
          np     = (b == CH_COMMA) ? PH_KEY : PH_DONE_OK;
        end else if (ws) begin
          // full buffer: release held bytes early, then hold this one unless it is the final byte
          f_en  = (cnt_q == CW'(WS_DEPTH));
          f_ovf = 1'b1;
          s_en  = !last;
        end else begin
          f_en = (cnt_q != '0);
          m_en = 1'b1;
        end
      end
      PH_AFTER_VAL: begin
        if (!ws) np = (b == CH_COMMA) ? PH_KEY : PH_DONE_OK;
      end
      default: begin
        np = phase_q;
      end
    endcase
  end

  assign pair_en  = last && (np == PH_COLON || np == PH_VAL_STR ||
                             np == PH_VAL_ESC || np == PH_BARE);
  assign end_kind = (np == PH_START || np == PH_DONE_BAD) ? KIND_REJECT : KIND_ACCEPT;

  // ---- plan and state registers ----
  logic          acc;
  logic          m_en_q, f_ovf_q, s_en_q, pair_q, end_q;
  kind_e         m_kind_q, end_kind_q;
  logic [7:0]    m_byte_q;
  logic [CW-1:0] flen_q;
  logic [AW-1:0] idx_q;
  logic          flush_last;
  logic [7:0]    rdata;

  assign acc = cmd_i.take && in_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cnt_q   <= '0;
      m_en_q  <= 1'b0;
      s_en_q  <= 1'b0;
      pair_q  <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      if (acc) begin
        phase_q <= last ? PH_START : np;
        m_en_q  <= m_en;
        s_en_q  <= s_en;
        pair_q  <= pair_en;
        end_q   <= last;
        if (last || clr || f_en) begin
          cnt_q <= '0;
        end
      end else if (cmd_i.main_step && s_en_q) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      m_kind_q   <= m_kind;
      m_byte_q   <= m_byte;
      f_ovf_q    <= f_ovf;
      end_kind_q <= end_kind;
      flen_q     <= cnt_q;
      idx_q      <= '0;
    end else if (cmd_i.flush_emit) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  assign flush_last = ((CW'(idx_q) + CW'(1)) == flen_q);

  fjot_ram #(
    .WIDTH(8),
    .DEPTH(WS_DEPTH)
  ) u_ws_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.main_step && s_en_q),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(m_byte_q),
    .re_i   (cmd_i.flush_rd),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  // ---- result register ----
  logic       out_valid_q;
  kind_e      out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_ovf_q, out_last_q;
  logic       out_free;

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.flush_emit || cmd_i.pair_emit || cmd_i.end_emit ||
                 (cmd_i.main_step && m_en_q)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.flush_emit) begin
      out_kind_q <= KIND_VAL;
      out_byte_q <= rdata;
      out_ovf_q  <= f_ovf_q;
      out_last_q <= flush_last && !m_en_q && !pair_q && !end_q;
    end else if (cmd_i.main_step && m_en_q) begin
      out_kind_q <= m_kind_q;
      out_byte_q <= m_byte_q;
      out_ovf_q  <= 1'b0;
      out_last_q <= !pair_q && !end_q;
    end else if (cmd_i.pair_emit) begin
      out_kind_q <= KIND_PAIR;
      out_byte_q <= '0;
      out_ovf_q  <= 1'b0;
      out_last_q <= !end_q;
    end else if (cmd_i.end_emit) begin
      out_kind_q <= end_kind_q;
      out_byte_q <= '0;
      out_ovf_q  <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_kind    = out_kind_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.ws_overflow = out_ovf_q;
  assign out_o.run_last    = out_last_q;

  assign in_i.ready = cmd_i.take;

  always_comb begin
    sts_o            = '0;
    sts_o.in_valid   = in_i.valid;
    sts_o.plan_flush = f_en;
    sts_o.main_en    = m_en_q;
    sts_o.pair_en    = pair_q;
    sts_o.end_en     = end_q;
    sts_o.flush_last = flush_last;
    sts_o.out_free   = out_free;
  end

endmodule

`default_nettype wire
